### hdl/cst_pkg.sv
`default_nettype none

package cst_pkg;

    localparam int NUM_SETS_DEF  = 128;
    localparam int MAX_SEMS_DEF  = 32;
    localparam int VALUE_MAX_DEF = 32767;

    localparam int          PID_W      = 22;
    localparam int          CNT_W      = 16;
    localparam int          PERM_W     = 9;
    localparam logic [8:0]  WRITE_BITS = 9'o222;
    localparam int          CREATE_BIT = 9;
    localparam int          EXCL_BIT   = 10;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_GET_OR_CREATE = 3'd0,
        OP_SEM_OP        = 3'd1,
        OP_GET_VALUE     = 3'd2,
        OP_SET_VALUE     = 3'd3,
        OP_INCR_WAITERS  = 3'd4,
        OP_ZERO_WAITERS  = 3'd5,
        OP_LAST_PID      = 3'd6,
        OP_REMOVE        = 3'd7
    } opcode_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_INVALID  = 4'd1,
        ST_EXISTS   = 4'd2,
        ST_NO_ENTRY = 4'd3,
        ST_NO_SPACE = 4'd4,
        ST_TOO_BIG  = 4'd5,
        ST_RANGE    = 4'd6,
        ST_AGAIN    = 4'd7,
        ST_ACCESS   = 4'd8,
        ST_WAIT     = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_SEM,
        S_SCAN,
        S_CLEAR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  set_index;
        logic [31:0] lookup_key;
        logic [5:0]  set_size_req;
        logic [10:0] creation_flags;
        logic [5:0]  sem_number;
        logic [15:0] op_delta;
        logic        no_wait;
        logic        retry;
        logic [15:0] new_value;
        logic [21:0] process_id;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [6:0]  set_index_out;
        logic [21:0] read_value;
    } out_word_t;

endpackage

`default_nettype wire

### hdl/cst_meta_ram.sv
`default_nettype none

module cst_meta_ram #(
    parameter int NUM_SETS = cst_pkg::NUM_SETS_DEF,
    parameter int SET_W    = 7,
    parameter int SZ_W     = 6
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [SET_W-1:0]      waddr,
    input  wire logic [31:0]           wkey,
    input  wire logic [SZ_W-1:0]       wsize,
    input  wire logic [8:0]            wperm,
    input  wire logic [SET_W-1:0]      raddr,
    output logic      [31:0]           rkey,
    output logic      [SZ_W-1:0]       rsize,
    output logic      [8:0]            rperm
);
    import cst_pkg::*;

    localparam int WORD_W = 32 + SZ_W + PERM_W;

    logic [WORD_W-1:0] mem [NUM_SETS];
    logic [WORD_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wsize, wperm};
        end
        rd_reg <= mem[raddr];
    end

    assign rkey  = rd_reg[WORD_W-1 -: 32];
    assign rsize = rd_reg[PERM_W +: SZ_W];
    assign rperm = rd_reg[PERM_W-1:0];

endmodule

`default_nettype wire

### hdl/cst_sem_ram.sv
`default_nettype none

module cst_sem_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int VAL_W  = 15
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [ADDR_W-1:0]       waddr,
    input  wire logic [VAL_W-1:0]        wval,
    input  wire logic [21:0]             wpid,
    input  wire logic [15:0]             wincr,
    input  wire logic [15:0]             wzero,
    input  wire logic [ADDR_W-1:0]       raddr,
    output logic      [VAL_W-1:0]        rval,
    output logic      [21:0]             rpid,
    output logic      [15:0]             rincr,
    output logic      [15:0]             rzero
);
    import cst_pkg::*;

    localparam int WORD_W = VAL_W + PID_W + 2 * CNT_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wval, wpid, wincr, wzero};
        end
        rd_reg <= mem[raddr];
    end

    assign rval  = rd_reg[WORD_W-1 -: VAL_W];
    assign rpid  = rd_reg[2*CNT_W +: PID_W];
    assign rincr = rd_reg[CNT_W +: CNT_W];
    assign rzero = rd_reg[CNT_W-1:0];

endmodule

`default_nettype wire

### hdl/counting_semaphore_table.sv
`default_nettype none

// Table of counting semaphore sets. One request word in, one result word out.
// Set keys, sizes and permissions sit in a RAM with a registered read; semaphore
// value, last pid and both waiter counts sit in a second RAM addressed by
// set * MAX_SEMS + sem_number. Valid bits per set are flops cleared by reset.
// Sequence: a request on an unknown set, remove, or an oversized create goes
// straight to the result; sem_op, get/set value and the waiter/pid reads do
// meta read, semaphore read-modify-write (skipped on a bad sem_number or a
// sem_op without write bits) and result. get_or_create scans the key RAM one
// entry per cycle, stops on a key match, then zeroes a new set's semaphores.
// The next request is taken while the previous result waits at the output.

module counting_semaphore_table #(
    parameter int NUM_SETS  = cst_pkg::NUM_SETS_DEF,
    parameter int MAX_SEMS  = cst_pkg::MAX_SEMS_DEF,
    parameter int VALUE_MAX = cst_pkg::VALUE_MAX_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cst_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cst_pkg::out_word_t     out_data
);
    import cst_pkg::*;

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SCN_W  = $clog2(NUM_SETS + 1);
    localparam int SZ_W   = $clog2(MAX_SEMS + 1);
    localparam int DEPTH  = NUM_SETS * MAX_SEMS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VAL_W  = $clog2(VALUE_MAX + 1);

    state_t state_reg, state_next;
    in_word_t req_reg, req_next;
    out_word_t res_reg, res_next;
    out_word_t out_reg;
    logic out_valid_reg;
    logic valid_reg [NUM_SETS];

    logic [SCN_W-1:0] scan_idx_reg, scan_idx_next;
    logic chk_vld_reg, chk_vld_next;
    logic [SET_W-1:0] chk_idx_reg, chk_idx_next;
    logic free_vld_reg, free_vld_next;
    logic [SET_W-1:0] free_idx_reg, free_idx_next;
    logic [SZ_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic valid_set, valid_clr;
    logic [SET_W-1:0] valid_idx;

    logic meta_we;
    logic [SET_W-1:0] meta_raddr;
    logic [31:0] meta_rkey;
    logic [SZ_W-1:0] meta_rsize;
    logic [8:0] meta_rperm;

    logic sem_we;
    logic [ADDR_W-1:0] sem_waddr, sem_addr;
    logic [VAL_W-1:0] sem_rval, sem_wval;
    logic [21:0] sem_rpid, sem_wpid;
    logic [15:0] sem_rincr, sem_wincr, sem_rzero, sem_wzero;

    logic [31:0] in_set_wide, req_set_wide;
    logic [SET_W-1:0] in_set_sel, req_set_sel;
    logic in_set_ok;
    logic accept, out_free;

    logic chk_valid, key_match, free_now, last_chk;
    logic [SET_W-1:0] free_idx_now;

    logic signed [17:0] d_ext, v_ext, sum, mag;
    logic nval_bad;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign in_set_wide  = 32'(in_data.set_index);
    assign in_set_sel   = in_set_wide[SET_W-1:0];
    assign in_set_ok    = (in_set_wide < 32'(NUM_SETS)) && valid_reg[in_set_sel];
    assign req_set_wide = 32'(req_reg.set_index);
    assign req_set_sel  = req_set_wide[SET_W-1:0];

    assign sem_addr = ADDR_W'(req_set_sel) * ADDR_W'(MAX_SEMS)
                    + ADDR_W'(req_reg.sem_number);

    assign chk_valid    = valid_reg[chk_idx_reg];
    assign key_match    = chk_vld_reg && chk_valid && (req_reg.lookup_key != 32'd0)
                        && (meta_rkey == req_reg.lookup_key);
    assign free_now     = free_vld_reg || (chk_vld_reg && !chk_valid);
    assign free_idx_now = free_vld_reg ? free_idx_reg : chk_idx_reg;
    assign last_chk     = chk_vld_reg && (32'(chk_idx_reg) == 32'(NUM_SETS - 1));

    assign d_ext    = 18'($signed(req_reg.op_delta));
    assign v_ext    = 18'(sem_rval);
    assign sum      = v_ext + d_ext;
    assign mag      = -d_ext;
    assign nval_bad = req_reg.new_value[15]
                   || (32'(req_reg.new_value) > 32'(VALUE_MAX));

    assign meta_raddr = (state_reg == S_IDLE) ? in_set_sel : scan_idx_reg[SET_W-1:0];

    cst_meta_ram #(
        .NUM_SETS(NUM_SETS),
        .SET_W   (SET_W),
        .SZ_W    (SZ_W)
    ) u_meta (
        .clk  (clk),
        .we   (meta_we),
        .waddr(free_idx_now),
        .wkey (req_reg.lookup_key),
        .wsize(SZ_W'(req_reg.set_size_req)),
        .wperm(req_reg.creation_flags[8:0]),
        .raddr(meta_raddr),
        .rkey (meta_rkey),
        .rsize(meta_rsize),
        .rperm(meta_rperm)
    );

    cst_sem_ram #(
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W),
        .VAL_W (VAL_W)
    ) u_sem (
        .clk  (clk),
        .we   (sem_we),
        .waddr(sem_waddr),
        .wval (sem_wval),
        .wpid (sem_wpid),
        .wincr(sem_wincr),
        .wzero(sem_wzero),
        .raddr(sem_addr),
        .rval (sem_rval),
        .rpid (sem_rpid),
        .rincr(sem_rincr),
        .rzero(sem_rzero)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode_t'(in_data.opcode) == OP_GET_OR_CREATE)
                    begin
                        state_next = (32'(in_data.set_size_req) > 32'(MAX_SEMS))
                                   ? S_RESP : S_SCAN;
                    end
                    else if (!in_set_ok || opcode_t'(in_data.opcode) == OP_REMOVE)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_META;
                    end
                end
            end
            S_META:
            begin
                if (opcode_t'(req_reg.opcode) == OP_SEM_OP)
                begin
                    state_next = ((meta_rperm & WRITE_BITS) == 9'd0
                               || 32'(req_reg.sem_number) >= 32'(meta_rsize))
                               ? S_RESP : S_SEM;
                end
                else
                begin
                    state_next = (32'(req_reg.sem_number) >= 32'(meta_rsize))
                               ? S_RESP : S_SEM;
                end
            end
            S_SEM:
            begin
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (key_match)
                begin
                    state_next = S_RESP;
                end
                else if (last_chk)
                begin
                    if ((req_reg.lookup_key != 32'd0 && !req_reg.creation_flags[CREATE_BIT])
                        || !free_now)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                if (32'(clr_cnt_reg) == 32'(req_reg.set_size_req))
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        req_next      = req_reg;
        res_next      = res_reg;
        scan_idx_next = scan_idx_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        clr_cnt_next  = clr_cnt_reg;
        valid_set     = 1'b0;
        valid_clr     = 1'b0;
        valid_idx     = req_set_sel;
        meta_we       = 1'b0;
        sem_we        = 1'b0;
        sem_waddr     = sem_addr;
        sem_wval      = sem_rval;
        sem_wpid      = sem_rpid;
        sem_wincr     = sem_rincr;
        sem_wzero     = sem_rzero;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = in_data;
                    res_next      = '0;
                    res_next.status = ST_OK;
                    scan_idx_next = '0;
                    free_vld_next = 1'b0;
                    clr_cnt_next  = '0;
                    if (opcode_t'(in_data.opcode) == OP_GET_OR_CREATE)
                    begin
                        if (32'(in_data.set_size_req) > 32'(MAX_SEMS))
                        begin
                            res_next.status = ST_INVALID;
                        end
                    end
                    else if (!in_set_ok)
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else if (opcode_t'(in_data.opcode) == OP_REMOVE)
                    begin
                        valid_clr = 1'b1;
                        valid_idx = in_set_sel;
                    end
                end
            end
            S_META:
            begin
                if (opcode_t'(req_reg.opcode) == OP_SEM_OP)
                begin
                    if ((meta_rperm & WRITE_BITS) == 9'd0)
                    begin
                        res_next.status = ST_ACCESS;
                    end
                    else if (32'(req_reg.sem_number) >= 32'(meta_rsize))
                    begin
                        res_next.status = ST_TOO_BIG;
                    end
                end
                else if (32'(req_reg.sem_number) >= 32'(meta_rsize))
                begin
                    res_next.status = ST_INVALID;
                end
            end
            S_SEM:
            begin
                case (opcode_t'(req_reg.opcode))
                    OP_SEM_OP:
                    begin
                        if (!d_ext[17] && d_ext != 18'sd0)
                        begin
                            if (sum > 18'(VALUE_MAX))
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                sem_we   = 1'b1;
                                sem_wval = VAL_W'(sum);
                                sem_wpid = req_reg.process_id;
                            end
                        end
                        else if ((d_ext[17] && v_ext < mag)
                              || (!d_ext[17] && v_ext != 18'sd0))
                        begin
                            if (req_reg.no_wait)
                            begin
                                res_next.status = ST_AGAIN;
                            end
                            else
                            begin
                                res_next.status = ST_WAIT;
                                if (!req_reg.retry)
                                begin
                                    sem_we = 1'b1;
                                    if (d_ext[17])
                                    begin
                                        sem_wincr = (sem_rincr == COUNT_MAX)
                                                  ? sem_rincr : sem_rincr + 16'd1;
                                    end
                                    else
                                    begin
                                        sem_wzero = (sem_rzero == COUNT_MAX)
                                                  ? sem_rzero : sem_rzero + 16'd1;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            sem_we = 1'b1;
                            if (d_ext[17])
                            begin
                                sem_wval = VAL_W'(v_ext - mag);
                                sem_wpid = req_reg.process_id;
                                if (req_reg.retry && sem_rincr != 16'd0)
                                begin
                                    sem_wincr = sem_rincr - 16'd1;
                                end
                            end
                            else if (req_reg.retry && sem_rzero != 16'd0)
                            begin
                                sem_wzero = sem_rzero - 16'd1;
                            end
                        end
                    end
                    OP_GET_VALUE:
                    begin
                        res_next.read_value = 22'(sem_rval);
                    end
                    OP_SET_VALUE:
                    begin
                        if (nval_bad)
                        begin
                            res_next.status = ST_RANGE;
                        end
                        else
                        begin
                            sem_we   = 1'b1;
                            sem_wval = VAL_W'(req_reg.new_value);
                            sem_wpid = req_reg.process_id;
                        end
                    end
                    OP_INCR_WAITERS:
                    begin
                        res_next.read_value = 22'(sem_rincr);
                    end
                    OP_ZERO_WAITERS:
                    begin
                        res_next.read_value = 22'(sem_rzero);
                    end
                    default:
                    begin
                        res_next.read_value = sem_rpid;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (32'(scan_idx_reg) < 32'(NUM_SETS))
                begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[SET_W-1:0];
                    scan_idx_next = scan_idx_reg + SCN_W'(1);
                end
                free_vld_next = free_now;
                free_idx_next = free_idx_now;
                if (key_match)
                begin
                    chk_vld_next = 1'b0;
                    if (req_reg.creation_flags[CREATE_BIT] && req_reg.creation_flags[EXCL_BIT])
                    begin
                        res_next.status = ST_EXISTS;
                    end
                    else if (32'(req_reg.set_size_req) > 32'(meta_rsize))
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else
                    begin
                        res_next.set_index_out = 7'(chk_idx_reg);
                    end
                end
                else if (last_chk)
                begin
                    chk_vld_next = 1'b0;
                    if (req_reg.lookup_key != 32'd0 && !req_reg.creation_flags[CREATE_BIT])
                    begin
                        res_next.status = ST_NO_ENTRY;
                    end
                    else if (!free_now)
                    begin
                        res_next.status = ST_NO_SPACE;
                    end
                    else
                    begin
                        meta_we   = 1'b1;
                        valid_set = 1'b1;
                        valid_idx = free_idx_now;
                        res_next.set_index_out = 7'(free_idx_now);
                    end
                end
            end
            S_CLEAR:
            begin
                if (32'(clr_cnt_reg) != 32'(req_reg.set_size_req))
                begin
                    sem_we       = 1'b1;
                    sem_waddr    = ADDR_W'(free_idx_reg) * ADDR_W'(MAX_SEMS)
                                 + ADDR_W'(clr_cnt_reg);
                    sem_wval     = '0;
                    sem_wpid     = '0;
                    sem_wincr    = '0;
                    sem_wzero    = '0;
                    clr_cnt_next = clr_cnt_reg + SZ_W'(1);
                end
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            free_vld_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            clr_cnt_reg   <= '0;
            for (int i = 0; i < NUM_SETS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            free_vld_reg <= free_vld_next;
            scan_idx_reg <= scan_idx_next;
            clr_cnt_reg  <= clr_cnt_next;
            if (valid_set)
            begin
                valid_reg[valid_idx] <= 1'b1;
            end
            else if (valid_clr)
            begin
                valid_reg[valid_idx] <= 1'b0;
            end
            if (state_reg == S_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        if (state_reg == S_RESP && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_sem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        sem_we |-> (state_reg == S_SEM || state_reg == S_CLEAR))
        else $error("semaphore RAM written outside update or clear");

    a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not handed to output register");

    a_meta_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        meta_we |-> (state_reg == S_SCAN && valid_set))
        else $error("set table written outside creation");

endmodule

`default_nettype wire

### test/testbench.sv
module testbench;
    import cst_pkg::*;

    localparam int NSETS = 128;
    localparam int NSEMS = 32;
    localparam int VMAX  = 32767;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    counting_semaphore_table DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #1 clk = ~clk;

    // shadow of the semaphore table
    bit          tbl_valid [NSETS];
    logic [31:0] tbl_key [NSETS];
    int          tbl_size [NSETS];
    logic [8:0]  tbl_perm [NSETS];
    int          sem_val [NSETS*NSEMS];
    int          sem_pid [NSETS*NSEMS];
    int          incr_wait [NSETS*NSEMS];
    int          zero_wait [NSETS*NSEMS];

    in_word_t  pending_words [$];
    out_word_t expected_results [$];
    int        errors = 0;
    bit        quiet_tail = 0;
    bit        hold_out = 0;
    int        send_gap = 0;
    int        recv_gap = 0;

    // acceptance as seen at the last rising edge
    logic      in_ready_q = 1'b0;

    function automatic out_word_t predict_result(in_word_t w);
        out_word_t r;
        int set, num, s, req, i, delta, nval;
        bit found, create, blocked;
        r = '0;
        set = int'(w.set_index);
        num = int'(w.sem_number);
        req = int'(w.set_size_req);
        delta = int'($signed(w.op_delta));
        nval = int'($signed(w.new_value));
        create = w.creation_flags[CREATE_BIT];
        r.status = ST_OK;
        if (opcode_t'(w.opcode) == OP_GET_OR_CREATE)
        begin
            found = 0;
            if (req > NSEMS)
            begin
                r.status = ST_INVALID;
                return r;
            end
            if (w.lookup_key != 0)
            begin
                for (i = 0; i < NSETS; i++)
                    if (!found && tbl_valid[i] && tbl_key[i] == w.lookup_key) found = 1;
                for (i = 0; i < NSETS; i++)
                    if (tbl_valid[i] && tbl_key[i] == w.lookup_key) break;
                if (found)
                begin
                    if (create && w.creation_flags[EXCL_BIT]) r.status = ST_EXISTS;
                    else if (req > tbl_size[i]) r.status = ST_INVALID;
                    else r.set_index_out = 7'(i);
                    return r;
                end
                if (!create)
                begin
                    r.status = ST_NO_ENTRY;
                    return r;
                end
            end
            for (i = 0; i < NSETS; i++)
                if (!tbl_valid[i]) break;
            if (i >= NSETS)
            begin
                r.status = ST_NO_SPACE;
                return r;
            end
            tbl_valid[i] = 1;
            tbl_key[i] = w.lookup_key;
            tbl_size[i] = req;
            tbl_perm[i] = w.creation_flags[8:0];
            for (int n = 0; n < req; n++)
            begin
                sem_val[i*NSEMS+n] = 0;
                sem_pid[i*NSEMS+n] = 0;
                incr_wait[i*NSEMS+n] = 0;
                zero_wait[i*NSEMS+n] = 0;
            end
            r.set_index_out = 7'(i);
            return r;
        end
        if (!tbl_valid[set])
        begin
            r.status = ST_INVALID;
            return r;
        end
        s = set*NSEMS + num;
        case (opcode_t'(w.opcode))
            OP_REMOVE: tbl_valid[set] = 0;
            OP_SEM_OP:
            begin
                if ((tbl_perm[set] & WRITE_BITS) == 0) r.status = ST_ACCESS;
                else if (num >= tbl_size[set]) r.status = ST_TOO_BIG;
                else if (delta > 0)
                begin
                    if (sem_val[s] + delta > VMAX) r.status = ST_RANGE;
                    else
                    begin
                        sem_val[s] += delta;
                        sem_pid[s] = int'(w.process_id);
                    end
                end
                else
                begin
                    blocked = (delta < 0) ? (sem_val[s] < -delta) : (sem_val[s] != 0);
                    if (blocked)
                    begin
                        if (w.no_wait) r.status = ST_AGAIN;
                        else
                        begin
                            r.status = ST_WAIT;
                            if (!w.retry)
                            begin
                                if (delta < 0)
                                begin
                                    if (incr_wait[s] < 65535) incr_wait[s]++;
                                end
                                else if (zero_wait[s] < 65535) zero_wait[s]++;
                            end
                        end
                    end
                    else
                    begin
                        if (w.retry)
                        begin
                            if (delta < 0)
                            begin
                                if (incr_wait[s] > 0) incr_wait[s]--;
                            end
                            else if (zero_wait[s] > 0) zero_wait[s]--;
                        end
                        if (delta < 0)
                        begin
                            sem_val[s] += delta;
                            sem_pid[s] = int'(w.process_id);
                        end
                    end
                end
            end
            default:
            begin
                if (num >= tbl_size[set]) r.status = ST_INVALID;
                else case (opcode_t'(w.opcode))
                    OP_GET_VALUE: r.read_value = 22'(sem_val[s]);
                    OP_SET_VALUE:
                    begin
                        if (nval < 0 || nval > VMAX) r.status = ST_RANGE;
                        else
                        begin
                            sem_val[s] = nval;
                            sem_pid[s] = int'(w.process_id);
                        end
                    end
                    OP_INCR_WAITERS: r.read_value = 22'(incr_wait[s]);
                    OP_ZERO_WAITERS: r.read_value = 22'(zero_wait[s]);
                    default: r.read_value = 22'(sem_pid[s]);
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        w.opcode = 3'($urandom_range(0, 7));
        w.set_index = 7'($urandom);
        w.lookup_key = $urandom;
        w.set_size_req = 6'($urandom);
        w.creation_flags = 11'($urandom);
        w.sem_number = 6'($urandom);
        w.op_delta = 16'($urandom);
        w.no_wait = 1'($urandom);
        w.retry = 1'($urandom);
        w.new_value = 16'($urandom);
        w.process_id = 22'($urandom);
        return w;
    endfunction

    // mostly requests that hit live sets and real semaphores
    function automatic in_word_t shaped_word();
        in_word_t w;
        w = rand_word();
        w.lookup_key = $urandom_range(0, 12);
        w.set_size_req = 6'($urandom_range(0, 34));
        w.creation_flags[CREATE_BIT] = ($urandom_range(0, 3) != 0);
        w.creation_flags[8:0] = ($urandom_range(0, 5) == 0) ? 9'o444 : 9'o666;
        w.set_index = 7'($urandom_range(0, 15));
        w.sem_number = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0: w.op_delta = 16'($urandom_range(1, 5));
            1: w.op_delta = 16'(-$urandom_range(1, 5));
            2: w.op_delta = '0;
            default: w.op_delta = 16'($urandom);
        endcase
        w.new_value = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        w.opcode = ($urandom_range(0, 19) == 0) ? OP_REMOVE :
                   ($urandom_range(0, 5) == 0) ? OP_GET_OR_CREATE : 3'($urandom_range(1, 6));
        return w;
    endfunction

    function automatic in_word_t mk(opcode_t op, int set, int num);
        in_word_t w;
        w = '0;
        w.opcode = op;
        w.set_index = 7'(set);
        w.sem_number = 6'(num);
        w.process_id = 22'h3FFFFF;
        return w;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_q)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            if (hold_out) out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        in_ready_q <= in_valid && in_ready;
        if (in_valid && in_ready)
            expected_results.push_back(predict_result(in_data));
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected word: status %0d", out_data.status);
                errors++;
            end
            else
            begin
                out_word_t e;
                e = expected_results.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, out_data.status);
                    errors++;
                end
                if (out_data.set_index_out !== e.set_index_out)
                begin
                    $error("set_index_out: expected %0d, actual %0d",
                           e.set_index_out, out_data.set_index_out);
                    errors++;
                end
                if (out_data.read_value !== e.read_value)
                begin
                    $error("read_value: expected %0d, actual %0d",
                           e.read_value, out_data.read_value);
                    errors++;
                end
            end
        end
    end

    // long receiver stall while the sender keeps offering
    initial
    begin
        wait (rst_n);
        repeat (100) @(posedge clk);
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
    end

    initial
    begin
        in_word_t w;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed
        w = mk(OP_GET_OR_CREATE, 0, 0); w.lookup_key = 32'hFFFFFFFF; w.set_size_req = 6'd32;
        w.creation_flags = 11'h600 | 9'o666; pending_words.push_back(w);
        w.creation_flags = 11'h600; pending_words.push_back(w);
        w.creation_flags = '0; w.set_size_req = 6'd33; pending_words.push_back(w);
        w.set_size_req = 6'd63; w.lookup_key = 32'd5; pending_words.push_back(w);
        w.set_size_req = 6'd1; w.lookup_key = 32'd77; pending_words.push_back(w);
        w.lookup_key = '0; w.set_size_req = '0; w.creation_flags = 11'o444;
        pending_words.push_back(w);
        w = mk(OP_SEM_OP, 1, 0); pending_words.push_back(w);
        w = mk(OP_SEM_OP, 0, 31); w.op_delta = 16'sd32767; pending_words.push_back(w);
        w.op_delta = 16'sd1; pending_words.push_back(w);
        w.op_delta = 16'h8000; w.no_wait = 1'b1; pending_words.push_back(w);
        w.no_wait = 1'b0; pending_words.push_back(w);
        w.op_delta = '0; pending_words.push_back(w);
        w.sem_number = 6'd32; pending_words.push_back(w);
        w = mk(OP_INCR_WAITERS, 0, 31); pending_words.push_back(w);
        w = mk(OP_ZERO_WAITERS, 0, 31); pending_words.push_back(w);
        w = mk(OP_SET_VALUE, 0, 31); w.new_value = 16'h8000; pending_words.push_back(w);
        w.new_value = 16'h7FFF; pending_words.push_back(w);
        w.new_value = '0; pending_words.push_back(w);
        w = mk(OP_SEM_OP, 0, 31); w.retry = 1'b1; pending_words.push_back(w);
        w = mk(OP_GET_VALUE, 0, 31); pending_words.push_back(w);
        w = mk(OP_LAST_PID, 0, 31); pending_words.push_back(w);
        w = mk(OP_GET_VALUE, 0, 40); pending_words.push_back(w);
        w = mk(OP_REMOVE, 0, 0); pending_words.push_back(w);
        w = mk(OP_GET_VALUE, 127, 0); pending_words.push_back(w);
        // fill the table to reach no_space
        for (int i = 0; i < 130; i++)
        begin
            w = mk(OP_GET_OR_CREATE, 0, 0); w.set_size_req = 6'($urandom_range(0, 2));
            w.creation_flags = 11'o666; pending_words.push_back(w);
        end
        w = mk(OP_SEM_OP, 127, 0); w.op_delta = 16'sd1; pending_words.push_back(w);
        for (int i = 0; i < 127; i++) pending_words.push_back(mk(OP_REMOVE, i + 1, 0));
        for (int i = 0; i < 20; i++) pending_words.push_back(shaped_word());
        for (int i = 0; i < 650; i++)
            pending_words.push_back(($urandom_range(0, 9) == 0) ? rand_word() : shaped_word());
        wait (pending_words.size() < 60);
        quiet_tail = 1;
        wait (pending_words.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
